[hw/rtl/ile_pkg.sv]
package ile_pkg;

    // Field widths of the command and result transactions.
    localparam int OPCODE_W = 3;
    localparam int VALUE_W  = 16;
    localparam int POS_W    = 6;
    localparam int LENGTH_W = 7;
    localparam int STATUS_W = 2;

    typedef logic [OPCODE_W-1:0] t_opcode;
    typedef logic [STATUS_W-1:0] t_status;
    typedef logic [1:0]          t_mode;

    localparam t_opcode OP_PUSH_BACK  = 3'd0;
    localparam t_opcode OP_POP_BACK   = 3'd1;
    localparam t_opcode OP_PUSH_FRONT = 3'd2;
    localparam t_opcode OP_POP_FRONT  = 3'd3;
    localparam t_opcode OP_INSERT     = 3'd4;
    localparam t_opcode OP_REMOVE     = 3'd5;
    localparam t_opcode OP_READ       = 3'd6;

    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_BAD_INDEX = 2'd1;
    localparam t_status ST_FULL      = 2'd2;
    localparam t_status ST_EMPTY     = 2'd3;

    // What the row of cells does at a clock edge.
    localparam t_mode MODE_HOLD = 2'd0;
    localparam t_mode MODE_INS  = 2'd1;
    localparam t_mode MODE_DEL  = 2'd2;
    localparam t_mode MODE_READ = 2'd3;

endpackage

[hw/rtl/ile_cell.sv]
module ile_cell #(
    parameter int IDX_W    = 6,
    parameter int DATA_W   = 16,
    parameter int CELL_IDX = 0
) (
    input  logic                 i_clk,
    input  ile_pkg::t_mode       i_mode,
    input  logic [IDX_W-1:0]     i_idx,
    input  logic [DATA_W-1:0]    i_value,
    input  logic [DATA_W-1:0]    i_left,
    input  logic [DATA_W-1:0]    i_right,
    output logic [DATA_W-1:0]    o_data,
    output logic [DATA_W-1:0]    o_tap
);
    import ile_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic [DATA_W-1:0] r_data;
    logic [DATA_W-1:0] n_data;
    logic              at_idx;
    logic              above_idx;

    assign at_idx    = (i_idx == MY_IDX);
    assign above_idx = (MY_IDX > i_idx);

    always_comb begin
        n_data = r_data;
        unique case (i_mode)
            MODE_INS: begin
                // Cells above the gap move one place toward the back.
                if (above_idx) begin
                    n_data = i_left;
                end else if (at_idx) begin
                    n_data = i_value;
                end
            end
            MODE_DEL: begin
                if (above_idx || at_idx) begin
                    n_data = i_right;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    assign o_tap  = at_idx ? r_data : '0;

endmodule

[hw/rtl/indexed_list_engine_core.sv]
// Channel   Direction  Handshake                 Payload
// command   in         start high, busy low      i_opcode, i_value, i_position
// result    out        o_strobe, one cycle       o_read_value, o_length, o_status
//
// One transaction is taken in every cycle; busy stays low.
// Each command completes in the cycle it is accepted: every cell of the row
// shifts or holds at that clock edge, and the result is registered for the next cycle.
// Reset empties the list; the element cells themselves are not cleared.
// The receiver cannot stall, so each result is shown for exactly one cycle.
module indexed_list_engine_core #(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  ile_pkg::t_opcode          i_opcode,
    input  logic [ile_pkg::VALUE_W-1:0]  i_value,
    input  logic [ile_pkg::POS_W-1:0]    i_position,
    output logic                      o_strobe,
    output logic [ile_pkg::VALUE_W-1:0]  o_read_value,
    output logic [ile_pkg::LENGTH_W-1:0] o_length,
    output ile_pkg::t_status          o_status
);
    import ile_pkg::*;

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int MW = (CW > POS_W) ? CW : POS_W;

    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;
    logic                  r_strobe;
    logic [VALUE_W-1:0]    r_read_value;
    logic [LENGTH_W-1:0]   r_length;
    t_status               r_status;

    logic                  accept;
    logic                  full;
    logic                  empty;
    logic                  valid;
    logic [MW-1:0]         pos_m;
    logic [MW-1:0]         count_m;
    logic [MW-1:0]         pos_inc;
    logic [CW-1:0]         count_dec;
    t_mode                 mode;
    t_mode                 cell_mode;
    logic [IW-1:0]         idx;
    t_status               status;
    logic [DATA_WIDTH-1:0] value_w;
    logic [DATA_WIDTH-1:0] tap_or;
    logic [VALUE_W-1:0]    rd;

    logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
    logic [DATA_WIDTH-1:0] cell_tap  [CAPACITY];

    assign busy    = 1'b0;
    assign accept  = start && !busy;
    assign full    = (r_count == CW'(CAPACITY));
    assign empty   = (r_count == '0);
    assign pos_m   = MW'(i_position);
    assign count_m = MW'(r_count);
    assign valid   = (pos_m < count_m);
    assign pos_inc = pos_m + MW'(1);
    assign count_dec = r_count - CW'(1);
    assign value_w = DATA_WIDTH'(i_value);

    // Command decode: pick what the row does and where.
    always_comb begin
        status  = ST_OK;
        mode    = MODE_HOLD;
        idx     = '0;
        n_count = r_count;
        unique case (i_opcode)
            OP_PUSH_BACK: begin
                if (full) begin
                    status = ST_FULL;
                end else begin
                    mode    = MODE_INS;
                    idx     = r_count[IW-1:0];
                    n_count = r_count + CW'(1);
                end
            end
            OP_POP_BACK: begin
                if (empty) begin
                    status = ST_EMPTY;
                end else begin
                    mode    = MODE_DEL;
                    idx     = count_dec[IW-1:0];
                    n_count = count_dec;
                end
            end
            OP_PUSH_FRONT: begin
                if (full) begin
                    status = ST_FULL;
                end else begin
                    mode    = MODE_INS;
                    n_count = r_count + CW'(1);
                end
            end
            OP_POP_FRONT: begin
                if (empty) begin
                    status = ST_EMPTY;
                end else begin
                    mode    = MODE_DEL;
                    n_count = count_dec;
                end
            end
            OP_INSERT: begin
                if (!valid) begin
                    status = ST_BAD_INDEX;
                end else if (full) begin
                    status = ST_FULL;
                end else begin
                    // A non-zero index places the value after that element.
                    mode    = MODE_INS;
                    idx     = (pos_m == '0) ? '0 : pos_inc[IW-1:0];
                    n_count = r_count + CW'(1);
                end
            end
            OP_REMOVE: begin
                if (!valid) begin
                    status = ST_BAD_INDEX;
                end else begin
                    mode    = MODE_DEL;
                    idx     = pos_m[IW-1:0];
                    n_count = count_dec;
                end
            end
            OP_READ: begin
                if (!valid) begin
                    status = ST_BAD_INDEX;
                end else begin
                    mode = MODE_READ;
                    idx  = pos_m[IW-1:0];
                end
            end
            default: begin
                status = ST_OK;
            end
        endcase
    end

    assign cell_mode = accept ? mode : MODE_HOLD;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic [DATA_WIDTH-1:0] left_data;
            logic [DATA_WIDTH-1:0] right_data;
            if (g == 0) begin : g_first
                assign left_data = '0;
            end else begin : g_mid_l
                assign left_data = cell_data[g-1];
            end
            if (g == CAPACITY - 1) begin : g_last
                assign right_data = '0;
            end else begin : g_mid_r
                assign right_data = cell_data[g+1];
            end
            ile_cell #(
                .IDX_W    (IW),
                .DATA_W   (DATA_WIDTH),
                .CELL_IDX (g)
            ) u_cell (
                .i_clk   (i_clk),
                .i_mode  (cell_mode),
                .i_idx   (idx),
                .i_value (value_w),
                .i_left  (left_data),
                .i_right (right_data),
                .o_data  (cell_data[g]),
                .o_tap   (cell_tap[g])
            );
        end
    endgenerate

    // Only the addressed cell drives a non-zero tap.
    always_comb begin
        tap_or = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            tap_or = tap_or | cell_tap[k];
        end
    end

    assign rd = (mode == MODE_DEL || mode == MODE_READ) ? VALUE_W'(tap_or) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= accept;
            if (accept) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_read_value <= rd;
            r_length     <= LENGTH_W'(n_count);
            r_status     <= status;
        end
    end

    assign o_strobe     = r_strobe;
    assign o_read_value = r_read_value;
    assign o_length     = r_length;
    assign o_status     = r_status;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("element count exceeds capacity");

    a_strobe_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start))
        else $error("result without an accepted transaction");

    a_fail_keeps_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status != ST_OK) |-> (o_length == LENGTH_W'($past(r_count))))
        else $error("failed command changed the list length");

    a_fail_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status != ST_OK) |-> (o_read_value == '0))
        else $error("failed command returned data");

    a_len_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_length == LENGTH_W'($past(r_count))
                   || o_length == LENGTH_W'($past(r_count)) + LENGTH_W'(1)
                   || o_length == LENGTH_W'($past(r_count)) - LENGTH_W'(1)))
        else $error("list length moved by more than one");

endmodule
